[design/three_channel_ultrasonic_ranger_macros.svh]
`ifndef THREE_CHANNEL_ULTRASONIC_RANGER_MACROS_SVH
`define THREE_CHANNEL_ULTRASONIC_RANGER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define TCUR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TCUR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tcur_pkg.sv]
package tcur_pkg;

  localparam int TICK_W = 16;
  localparam int DIST_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int TRIG_LOW_TICKS = 2;
  localparam int TRIG_HIGH_TICKS = 10;

  // floor(n * 343 / 10000) == (n * CM_RECIP) >> CM_SHIFT for every 16-bit n
  localparam int CM_RECIP_W = 26;
  localparam int CM_SHIFT = 30;
  localparam logic [CM_RECIP_W-1:0] CM_RECIP = 26'd36829345;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_THR = 2'd2;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [DIST_W-1:0] FRONT_THR_RESET = 12'd15;
  localparam logic [DIST_W-1:0] SIDE_THR_RESET = 12'd10;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TLOW = 3'd1;
  localparam logic [2:0] PH_THIGH = 3'd2;
  localparam logic [2:0] PH_RISE = 3'd3;
  localparam logic [2:0] PH_HIGH = 3'd4;

  localparam logic [1:0] SENS_FRONT = 2'd0;
  localparam logic [1:0] SENS_LEFT = 2'd1;
  localparam logic [1:0] SENS_RIGHT = 2'd2;

  localparam logic [2:0] LED_FRONT_NEAR = 3'd1;
  localparam logic [2:0] LED_CLEAR = 3'd2;
  localparam logic [2:0] LED_LEFT_NEAR = 3'd3;
  localparam logic [2:0] LED_RIGHT_NEAR = 3'd4;

endpackage

[design/tcur_if.sv]
interface tcur_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_front;
  logic echo_left;
  logic echo_right;

  modport source (output valid, start_req, echo_front, echo_left, echo_right, input ready);
  modport sink (input valid, start_req, echo_front, echo_left, echo_right, output ready);
endinterface

interface tcur_res_if;
  logic valid;
  logic ready;
  logic trig_front;
  logic trig_left;
  logic trig_right;
  logic busy_res;
  logic done_res;
  logic [tcur_pkg::DIST_W-1:0] dist_front;
  logic [tcur_pkg::DIST_W-1:0] dist_left;
  logic [tcur_pkg::DIST_W-1:0] dist_right;
  logic near_front;
  logic near_left;
  logic near_right;
  logic [2:0] led_code;

  modport source (output valid, trig_front, trig_left, trig_right, busy_res, done_res,
                  dist_front, dist_left, dist_right, near_front, near_left, near_right,
                  led_code, input ready);
  modport sink (input valid, trig_front, trig_left, trig_right, busy_res, done_res,
                dist_front, dist_left, dist_right, near_front, near_left, near_right,
                led_code, output ready);
endinterface

[design/tcur_cm_conv.sv]
module tcur_cm_conv (
  input  logic [tcur_pkg::TICK_W-1:0] ticks,
  output logic [tcur_pkg::DIST_W-1:0] cm
);

  logic [tcur_pkg::TICK_W+tcur_pkg::CM_RECIP_W-1:0] prod;

  assign prod = {{tcur_pkg::CM_RECIP_W{1'b0}}, ticks}
              * {{tcur_pkg::TICK_W{1'b0}}, tcur_pkg::CM_RECIP};
  assign cm = prod[tcur_pkg::CM_SHIFT +: tcur_pkg::DIST_W];

endmodule

[design/three_channel_ultrasonic_ranger.sv]
// Channel  Dir  Payload                                              Handshake
// tick     in   start_req, echo_front, echo_left, echo_right         valid/ready
// result   out  trig_*, busy_res, done_res, dist_*, near_*, led_code valid/ready
// cfg      in   cfg_wen, cfg_idx, cfg_wdata                          write only
//
// One request per cycle unless output stalls; results show in the next cycle.
// The output register frees as its result is taken, so a request is taken
// whenever the output is empty or being drained in the same cycle.
// rst is synchronous: round idle, distances zero, thresholds and timeout
// back to defaults, output register empty.
module three_channel_ultrasonic_ranger (
  input  logic                               clk,
  input  logic                               rst,
  tcur_tick_if.sink                          tick,
  tcur_res_if.source                         result,
  input  logic                               cfg_wen,
  input  logic [tcur_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tcur_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [tcur_pkg::TICK_W-1:0] timeout;
  logic [tcur_pkg::DIST_W-1:0] front_thr;
  logic [tcur_pkg::DIST_W-1:0] side_thr;

  logic [2:0] phase, phase_next;
  logic [1:0] sensor_idx, sensor_idx_next;
  logic [tcur_pkg::TICK_W-1:0] tick_count, tick_count_next;
  logic [tcur_pkg::DIST_W-1:0] dist_front, dist_front_next;
  logic [tcur_pkg::DIST_W-1:0] dist_left, dist_left_next;
  logic [tcur_pkg::DIST_W-1:0] dist_right, dist_right_next;

  logic [2:0] work_phase;
  logic [1:0] work_idx;
  logic [tcur_pkg::TICK_W-1:0] work_tick;
  logic [tcur_pkg::TICK_W-1:0] tick_inc;
  logic [tcur_pkg::TICK_W-1:0] fin_count;
  logic [tcur_pkg::DIST_W-1:0] fin_cm;
  logic [2:0] trig;
  logic echo;
  logic busy;
  logic done;
  logic finish;
  logic near_front, near_left, near_right;
  logic [2:0] led;
  logic accept;
  logic res_valid;

  assign tick.ready = !res_valid || result.ready;
  assign accept = tick.valid && tick.ready;

  tcur_cm_conv u_cm_conv (
    .ticks (fin_count),
    .cm    (fin_cm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= tcur_pkg::TIMEOUT_RESET;
      front_thr <= tcur_pkg::FRONT_THR_RESET;
      side_thr <= tcur_pkg::SIDE_THR_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        tcur_pkg::REG_TIMEOUT: timeout <= cfg_wdata;
        tcur_pkg::REG_FRONT_THR: front_thr <= cfg_wdata[tcur_pkg::DIST_W-1:0];
        tcur_pkg::REG_SIDE_THR: side_thr <= cfg_wdata[tcur_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    work_phase = phase;
    work_idx = sensor_idx;
    work_tick = tick_count;
    if (phase == tcur_pkg::PH_IDLE && tick.start_req) begin
      work_phase = tcur_pkg::PH_TLOW;
      work_idx = tcur_pkg::SENS_FRONT;
      work_tick = '0;
    end

    unique case (work_idx)
      tcur_pkg::SENS_FRONT: echo = tick.echo_front;
      tcur_pkg::SENS_LEFT: echo = tick.echo_left;
      default: echo = tick.echo_right;
    endcase

    busy = work_phase != tcur_pkg::PH_IDLE;
    tick_inc = work_tick + 1'b1;
    phase_next = work_phase;
    sensor_idx_next = work_idx;
    tick_count_next = work_tick;
    trig = '0;
    finish = 1'b0;
    done = 1'b0;
    fin_count = '0;

    unique case (work_phase)
      tcur_pkg::PH_TLOW: begin
        if (tick_inc >= tcur_pkg::TICK_W'(tcur_pkg::TRIG_LOW_TICKS)) begin
          phase_next = tcur_pkg::PH_THIGH;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      tcur_pkg::PH_THIGH: begin
        unique case (work_idx)
          tcur_pkg::SENS_FRONT: trig[0] = 1'b1;
          tcur_pkg::SENS_LEFT: trig[1] = 1'b1;
          default: trig[2] = 1'b1;
        endcase
        if (tick_inc >= tcur_pkg::TICK_W'(tcur_pkg::TRIG_HIGH_TICKS)) begin
          phase_next = tcur_pkg::PH_RISE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      tcur_pkg::PH_RISE: begin
        if (echo) begin
          fin_count = tcur_pkg::TICK_W'(1);
          tick_count_next = tcur_pkg::TICK_W'(1);
          phase_next = tcur_pkg::PH_HIGH;
          finish = tcur_pkg::TICK_W'(1) >= timeout;
        end else begin
          tick_count_next = tick_inc;
          finish = tick_inc >= timeout;
        end
      end
      tcur_pkg::PH_HIGH: begin
        if (echo) begin
          fin_count = tick_inc;
          tick_count_next = tick_inc;
          finish = tick_inc >= timeout;
        end else begin
          fin_count = work_tick;
          finish = 1'b1;
        end
      end
      default: begin
        phase_next = tcur_pkg::PH_IDLE;
      end
    endcase

    dist_front_next = dist_front;
    dist_left_next = dist_left;
    dist_right_next = dist_right;
    if (finish) begin
      tick_count_next = '0;
      unique case (work_idx)
        tcur_pkg::SENS_FRONT: dist_front_next = fin_cm;
        tcur_pkg::SENS_LEFT: dist_left_next = fin_cm;
        default: dist_right_next = fin_cm;
      endcase
      if (work_idx == tcur_pkg::SENS_FRONT || work_idx == tcur_pkg::SENS_LEFT) begin
        sensor_idx_next = work_idx + 1'b1;
        phase_next = tcur_pkg::PH_TLOW;
      end else begin
        sensor_idx_next = tcur_pkg::SENS_FRONT;
        phase_next = tcur_pkg::PH_IDLE;
        done = 1'b1;
      end
    end

    near_front = dist_front_next < front_thr;
    near_left = dist_left_next < side_thr;
    near_right = dist_right_next < side_thr;
    priority if (near_right) begin
      led = tcur_pkg::LED_RIGHT_NEAR;
    end else if (near_left) begin
      led = tcur_pkg::LED_LEFT_NEAR;
    end else if (near_front) begin
      led = tcur_pkg::LED_FRONT_NEAR;
    end else begin
      led = tcur_pkg::LED_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tcur_pkg::PH_IDLE;
      sensor_idx <= tcur_pkg::SENS_FRONT;
      tick_count <= '0;
      dist_front <= '0;
      dist_left <= '0;
      dist_right <= '0;
    end else if (accept) begin
      phase <= phase_next;
      sensor_idx <= sensor_idx_next;
      tick_count <= tick_count_next;
      dist_front <= dist_front_next;
      dist_left <= dist_left_next;
      dist_right <= dist_right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.trig_front <= trig[0];
      result.trig_left <= trig[1];
      result.trig_right <= trig[2];
      result.busy_res <= busy;
      result.done_res <= done;
      result.dist_front <= dist_front_next;
      result.dist_left <= dist_left_next;
      result.dist_right <= dist_right_next;
      result.near_front <= near_front;
      result.near_left <= near_left;
      result.near_right <= near_right;
      result.led_code <= led;
    end
  end

  assign result.valid = res_valid;

endmodule

[design/tcur_checker.sv]
`include "three_channel_ultrasonic_ranger_macros.svh"

module tcur_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        trig_front,
  input logic                        trig_left,
  input logic                        trig_right,
  input logic                        busy_res,
  input logic                        done_res,
  input logic                        near_right,
  input logic [2:0]                  led_code,
  input logic [tcur_pkg::DIST_W-1:0] dist_right
);

  logic [2:0] trig;
  logic [tcur_pkg::DIST_W+8:0] held;

  assign trig = {trig_right, trig_left, trig_front};
  assign held = {trig, busy_res, done_res, near_right, led_code, dist_right};

  `TCUR_ASSERT_IMP(a_done_in_round, res_valid && done_res, busy_res, "done outside a round")
  `TCUR_ASSERT_IMP(a_one_trigger, res_valid, $onehot0(trig), "more than one trigger high")
  `TCUR_ASSERT_IMP(a_trig_busy, res_valid && trig != 3'b000, busy_res, "trigger while idle")
  `TCUR_ASSERT_IMP(a_led_right, res_valid && near_right,
                   led_code == tcur_pkg::LED_RIGHT_NEAR, "led code ignores right near")
  `TCUR_ASSERT_NXT(a_hold_stalled, res_valid && !res_ready,
                   res_valid && $stable(held), "stalled result changed")

endmodule

bind three_channel_ultrasonic_ranger tcur_checker u_tcur_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .trig_front (result.trig_front),
  .trig_left  (result.trig_left),
  .trig_right (result.trig_right),
  .busy_res   (result.busy_res),
  .done_res   (result.done_res),
  .near_right (result.near_right),
  .led_code   (result.led_code),
  .dist_right (result.dist_right)
);
